### hdl/vrp_pkg.sv
// Shared types, constants and the sine table for the vertex rotate/project pipeline.
// Used by vrp_rot, vrp_div and vertex_rotate_project; depends on nothing.
`default_nettype none

package vrp_pkg;

  // register indexes on the configuration port
  localparam logic [2:0] REG_CAMERA_HEIGHT = 3'd0;
  localparam logic [2:0] REG_NEAR_CLIP     = 3'd1;
  localparam logic [2:0] REG_FOCAL_LENGTH  = 3'd2;
  localparam logic [2:0] REG_CENTER_X      = 3'd3;
  localparam logic [2:0] REG_CENTER_Y      = 3'd4;

  // rotation axis codes
  localparam int AXIS_Z = 0;
  localparam int AXIS_X = 1;
  localparam int AXIS_Y = 2;

  localparam int CW  = 18;  // rotated coordinate width
  localparam int TW  = 10;  // signed trig value width (+/-256)
  localparam int PW  = CW + TW;
  localparam int DW  = 33;  // dividend magnitude width
  localparam int VW  = 21;  // divisor width

  localparam logic [8:0] QSIN [65] = '{
    9'd0,   9'd6,   9'd13,  9'd19,  9'd25,  9'd31,  9'd38,  9'd44,  9'd50,
    9'd56,  9'd62,  9'd68,  9'd74,  9'd80,  9'd86,  9'd92,  9'd98,  9'd104,
    9'd109, 9'd115, 9'd121, 9'd126, 9'd132, 9'd137, 9'd142, 9'd147, 9'd152,
    9'd157, 9'd162, 9'd167, 9'd172, 9'd177, 9'd181, 9'd185, 9'd190, 9'd194,
    9'd198, 9'd202, 9'd206, 9'd209, 9'd213, 9'd216, 9'd220, 9'd223, 9'd226,
    9'd229, 9'd231, 9'd234, 9'd237, 9'd239, 9'd241, 9'd243, 9'd245, 9'd247,
    9'd248, 9'd250, 9'd251, 9'd252, 9'd253, 9'd254, 9'd255, 9'd255, 9'd256,
    9'd256, 9'd256
  };

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
    logic [7:0]           az;
    logic [7:0]           ax;
    logic [7:0]           ay;
    logic signed [20:0]   tx;
    logic signed [20:0]   ty;
    logic signed [15:0]   tz;
  } vtx_t;

  typedef struct packed {
    logic signed [21:0] cam_x;
    logic signed [21:0] cam_depth;
    logic signed [21:0] cam_z;
    logic               proj;
    logic               neg_x;
    logic               neg_z;
  } side_t;

  function automatic logic signed [TW-1:0] sin_of(input logic [7:0] a);
    logic [6:0] o;
    logic [6:0] r;
    logic [TW-1:0] pos;
    logic [TW-1:0] mir;
    logic signed [TW-1:0] res;
    o   = {1'b0, a[5:0]};
    r   = 7'd64 - o;
    pos = {1'b0, QSIN[o]};
    mir = {1'b0, QSIN[r]};
    case (a[7:6])
      2'd0:    res = $signed(pos);
      2'd1:    res = $signed(mir);
      2'd2:    res = -$signed(pos);
      default: res = -$signed(mir);
    endcase
    return res;
  endfunction

  function automatic logic signed [TW-1:0] cos_of(input logic [7:0] a);
    return sin_of(a + 8'd64);
  endfunction

endpackage

`default_nettype wire

### hdl/vrp_rot.sv
// One plane rotation in two register stages: products, then shift and sum.
// Depends on vrp_pkg for the vertex word type and the sine table.
`default_nettype none

module vrp_rot #(
  parameter int AXIS          = 0,
  parameter int FRACTION_BITS = 8
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         en,
  input  wire logic         in_valid,
  input  vrp_pkg::vtx_t     in_vtx,
  output logic              out_valid,
  output vrp_pkg::vtx_t     out_vtx
);

  logic [7:0]                        ang;
  logic signed [vrp_pkg::CW-1:0]     a, b;
  logic signed [vrp_pkg::TW-1:0]     s, c;
  logic signed [vrp_pkg::PW-1:0]     pac_r, pbs_r, pas_r, pbc_r;
  logic signed [vrp_pkg::PW-1:0]     na, nb;
  logic                              v1_r, v2_r;
  vrp_pkg::vtx_t                     vtx1_r, vtx2_r, vtx_nxt;

  // pick the pair that turns: Z (x,y), X (y,z), Y (z,x)
  always_comb begin
    if (AXIS == vrp_pkg::AXIS_Z) begin
      ang = in_vtx.az; a = in_vtx.x; b = in_vtx.y;
    end else if (AXIS == vrp_pkg::AXIS_X) begin
      ang = in_vtx.ax; a = in_vtx.y; b = in_vtx.z;
    end else begin
      ang = in_vtx.ay; a = in_vtx.z; b = in_vtx.x;
    end
    s = vrp_pkg::sin_of(ang);
    c = vrp_pkg::cos_of(ang);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pac_r  <= vrp_pkg::PW'(a) * vrp_pkg::PW'(c);
      pbs_r  <= vrp_pkg::PW'(b) * vrp_pkg::PW'(s);
      pas_r  <= vrp_pkg::PW'(a) * vrp_pkg::PW'(s);
      pbc_r  <= vrp_pkg::PW'(b) * vrp_pkg::PW'(c);
      vtx1_r <= in_vtx;
      vtx2_r <= vtx_nxt;
    end
  end

  // floor shift of each product, then combine
  always_comb begin
    na = (pac_r >>> FRACTION_BITS) - (pbs_r >>> FRACTION_BITS);
    nb = (pas_r >>> FRACTION_BITS) + (pbc_r >>> FRACTION_BITS);
    vtx_nxt = vtx1_r;
    if (AXIS == vrp_pkg::AXIS_Z) begin
      vtx_nxt.x = vrp_pkg::CW'(na); vtx_nxt.y = vrp_pkg::CW'(nb);
    end else if (AXIS == vrp_pkg::AXIS_X) begin
      vtx_nxt.y = vrp_pkg::CW'(na); vtx_nxt.z = vrp_pkg::CW'(nb);
    end else begin
      vtx_nxt.z = vrp_pkg::CW'(na); vtx_nxt.x = vrp_pkg::CW'(nb);
    end
  end

  assign out_valid = v2_r;
  assign out_vtx   = vtx2_r;

endmodule

`default_nettype wire

### hdl/vrp_div.sv
// Pipelined restoring divider, one quotient bit per stage, two dividends
// over one shared divisor. Depends on vrp_pkg for widths and the side word.
`default_nettype none

module vrp_div (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               en,
  input  wire logic               in_valid,
  input  wire logic [vrp_pkg::DW-1:0] in_num_a,
  input  wire logic [vrp_pkg::DW-1:0] in_num_b,
  input  wire logic [vrp_pkg::VW-1:0] in_den,
  input  vrp_pkg::side_t          in_side,
  output logic                    out_valid,
  output logic [vrp_pkg::DW-1:0]  out_quo_a,
  output logic [vrp_pkg::DW-1:0]  out_quo_b,
  output vrp_pkg::side_t          out_side
);

  localparam int DW = vrp_pkg::DW;
  localparam int VW = vrp_pkg::VW;

  logic                 v_r    [DW];
  logic [DW-1:0]        na_r   [DW];
  logic [DW-1:0]        nb_r   [DW];
  logic [VW-1:0]        ra_r   [DW];
  logic [VW-1:0]        rb_r   [DW];
  logic [VW-1:0]        d_r    [DW];
  vrp_pkg::side_t       side_r [DW];

  for (genvar g = 0; g < DW; g++) begin : g_stage
    logic           v_p;
    logic [DW-1:0]  na_p, nb_p;
    logic [VW-1:0]  ra_p, rb_p, d_p;
    vrp_pkg::side_t side_p;
    logic [VW:0]    ta, tb;
    logic [VW+1:0]  da, db;
    logic           qa, qb;

    if (g == 0) begin : g_first
      assign v_p    = in_valid;
      assign na_p   = in_num_a;
      assign nb_p   = in_num_b;
      assign ra_p   = '0;
      assign rb_p   = '0;
      assign d_p    = in_den;
      assign side_p = in_side;
    end else begin : g_next
      assign v_p    = v_r[g-1];
      assign na_p   = na_r[g-1];
      assign nb_p   = nb_r[g-1];
      assign ra_p   = ra_r[g-1];
      assign rb_p   = rb_r[g-1];
      assign d_p    = d_r[g-1];
      assign side_p = side_r[g-1];
    end

    // bring down the top dividend bit, try the subtract
    assign ta = {ra_p, na_p[DW-1]};
    assign tb = {rb_p, nb_p[DW-1]};
    assign da = {1'b0, ta} - {2'b00, d_p};
    assign db = {1'b0, tb} - {2'b00, d_p};
    assign qa = ~da[VW+1];
    assign qb = ~db[VW+1];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[g] <= 1'b0;
      end else if (en) begin
        v_r[g] <= v_p;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        ra_r[g]   <= qa ? da[VW-1:0] : ta[VW-1:0];
        rb_r[g]   <= qb ? db[VW-1:0] : tb[VW-1:0];
        na_r[g]   <= {na_p[DW-2:0], qa};
        nb_r[g]   <= {nb_p[DW-2:0], qb};
        d_r[g]    <= d_p;
        side_r[g] <= side_p;
      end
    end
  end

  assign out_valid = v_r[DW-1];
  assign out_quo_a = na_r[DW-1];
  assign out_quo_b = nb_r[DW-1];
  assign out_side  = side_r[DW-1];

endmodule

`default_nettype wire

### hdl/vertex_rotate_project.sv
// Top level: input register, three rotations, translate, scale, magnitude, divide, output.
// Depends on vrp_pkg, vrp_rot and vrp_div.
//
//  channel  | ports           | word
//  ---------+-----------------+---------------------------------------------
//  input    | in_t*           | one vertex, angles and translation
//  result   | out_t*          | camera point, screen point, projected flag
//  config   | cfg_p*          | five registers at byte addresses 0,4,..,16
//
// One vertex per cycle unless a finished word is held at the output. The divider's
// 33 bit stages set the depth. Reset clears the valid bits and loads register defaults.
// When the output word is not taken, the whole pipeline holds in place.
`default_nettype none

module vertex_rotate_project #(
  parameter int FRACTION_BITS = 8
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // x[12:0] y[25:13] z[38:26] az[46:39] ax[54:47] ay[62:55]
  // tx[83:63] ty[104:84] tz[120:105]
  input  wire logic [127:0] in_tdata,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // cam_x[21:0] cam_depth[43:22] cam_z[65:44] screen_x[81:66] screen_y[97:82]
  output logic [103:0]      out_tdata,
  // projected[0]
  output logic              out_tuser,
  input  wire logic         cfg_psel,
  input  wire logic         cfg_penable,
  input  wire logic         cfg_pwrite,
  input  wire logic [4:0]   cfg_paddr,
  input  wire logic [31:0]  cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);

  logic signed [20:0] camh_r;
  logic [19:0]        near_r;
  logic [11:0]        focal_r;
  logic [11:0]        ctrx_r;
  logic [11:0]        ctry_r;
  logic [2:0]         reg_idx;
  logic               en;

  assign cfg_pready = 1'b1;
  assign reg_idx    = cfg_paddr[4:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      camh_r  <= 21'sd128;
      near_r  <= 20'd16;
      focal_r <= 12'd256;
      ctrx_r  <= 12'd320;
      ctry_r  <= 12'd240;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
      unique case (reg_idx)
        vrp_pkg::REG_CAMERA_HEIGHT: camh_r  <= $signed(cfg_pwdata[20:0]);
        vrp_pkg::REG_NEAR_CLIP:     near_r  <= cfg_pwdata[19:0];
        vrp_pkg::REG_FOCAL_LENGTH:  focal_r <= cfg_pwdata[11:0];
        vrp_pkg::REG_CENTER_X:      ctrx_r  <= cfg_pwdata[11:0];
        vrp_pkg::REG_CENTER_Y:      ctry_r  <= cfg_pwdata[11:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      vrp_pkg::REG_CAMERA_HEIGHT: cfg_prdata = 32'(camh_r);
      vrp_pkg::REG_NEAR_CLIP:     cfg_prdata = {12'd0, near_r};
      vrp_pkg::REG_FOCAL_LENGTH:  cfg_prdata = {20'd0, focal_r};
      vrp_pkg::REG_CENTER_X:      cfg_prdata = {20'd0, ctrx_r};
      vrp_pkg::REG_CENTER_Y:      cfg_prdata = {20'd0, ctry_r};
      default:                    cfg_prdata = '0;
    endcase
  end

  // advance everything unless a finished word is held at the output
  logic out_valid_r;
  assign en        = !out_valid_r || out_tready;
  assign in_tready = en;

  // input register
  logic          v0_r;
  vrp_pkg::vtx_t vtx0_r, vtx_in;

  always_comb begin
    vtx_in.x  = vrp_pkg::CW'($signed(in_tdata[12:0]));
    vtx_in.y  = vrp_pkg::CW'($signed(in_tdata[25:13]));
    vtx_in.z  = vrp_pkg::CW'($signed(in_tdata[38:26]));
    vtx_in.az = in_tdata[46:39];
    vtx_in.ax = in_tdata[54:47];
    vtx_in.ay = in_tdata[62:55];
    vtx_in.tx = $signed(in_tdata[83:63]);
    vtx_in.ty = $signed(in_tdata[104:84]);
    vtx_in.tz = $signed(in_tdata[120:105]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (en) begin
      v0_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vtx0_r <= vtx_in;
    end
  end

  logic          vz, vx, vy;
  vrp_pkg::vtx_t tz_vtx, tx_vtx, ty_vtx;

  vrp_rot #(.AXIS(vrp_pkg::AXIS_Z), .FRACTION_BITS(FRACTION_BITS)) u_rot_z (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(v0_r), .in_vtx(vtx0_r), .out_valid(vz), .out_vtx(tz_vtx)
  );

  vrp_rot #(.AXIS(vrp_pkg::AXIS_X), .FRACTION_BITS(FRACTION_BITS)) u_rot_x (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(vz), .in_vtx(tz_vtx), .out_valid(vx), .out_vtx(tx_vtx)
  );

  vrp_rot #(.AXIS(vrp_pkg::AXIS_Y), .FRACTION_BITS(FRACTION_BITS)) u_rot_y (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(vx), .in_vtx(tx_vtx), .out_valid(vy), .out_vtx(ty_vtx)
  );

  // translate and test against the near clip
  logic signed [22:0] cx, cy, cz;
  logic               vt_r;
  vrp_pkg::side_t     st_r, st_nxt;

  always_comb begin
    cx = 23'(ty_vtx.x) + 23'(ty_vtx.tx);
    cy = 23'(ty_vtx.y) + 23'(ty_vtx.ty);
    cz = 23'(ty_vtx.z) + 23'(ty_vtx.tz) - 23'(camh_r);
    st_nxt.cam_x     = cx[21:0];
    st_nxt.cam_depth = cy[21:0];
    st_nxt.cam_z     = cz[21:0];
    st_nxt.proj      = cy > $signed({3'b000, near_r});
    st_nxt.neg_x     = 1'b0;
    st_nxt.neg_z     = 1'b0;
  end

  // scale by the focal length
  logic               vm_r;
  logic signed [34:0] px_r, pz_r;
  vrp_pkg::side_t     sm_r;

  // take magnitudes for the divider
  logic                       va_r;
  logic [vrp_pkg::DW-1:0]     mx_r, mz_r;
  logic [vrp_pkg::VW-1:0]     den_r;
  vrp_pkg::side_t             sa_r, sa_nxt;
  logic signed [34:0]         mx, mz;

  always_comb begin
    mx = px_r[34] ? -px_r : px_r;
    mz = pz_r[34] ? -pz_r : pz_r;
    sa_nxt       = sm_r;
    sa_nxt.neg_x = px_r[34];
    sa_nxt.neg_z = pz_r[34];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vt_r <= 1'b0;
      vm_r <= 1'b0;
      va_r <= 1'b0;
    end else if (en) begin
      vt_r <= vy;
      vm_r <= vt_r;
      va_r <= vm_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_r  <= st_nxt;
      px_r  <= 35'(st_r.cam_x) * 35'($signed({1'b0, focal_r}));
      pz_r  <= 35'(st_r.cam_z) * 35'($signed({1'b0, focal_r}));
      sm_r  <= st_r;
      mx_r  <= mx[vrp_pkg::DW-1:0];
      mz_r  <= mz[vrp_pkg::DW-1:0];
      den_r <= sm_r.cam_depth[vrp_pkg::VW-1:0];
      sa_r  <= sa_nxt;
    end
  end

  logic                   vd;
  logic [vrp_pkg::DW-1:0] qx, qz;
  vrp_pkg::side_t         sd;

  vrp_div u_div (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(va_r), .in_num_a(mx_r), .in_num_b(mz_r), .in_den(den_r),
    .in_side(sa_r),
    .out_valid(vd), .out_quo_a(qx), .out_quo_b(qz), .out_side(sd)
  );

  // apply signs, offset from the view center, wrap to 16 bits; zero when not projected
  logic [15:0] qx16, qz16, sx, sy;
  logic [15:0] sx_r, sy_r;
  logic        proj_r;
  logic [21:0] ox_r, oy_r, oz_r;

  always_comb begin
    qx16 = sd.neg_x ? 16'(-qx[15:0]) : qx[15:0];
    qz16 = sd.neg_z ? 16'(-qz[15:0]) : qz[15:0];
    sx   = sd.proj ? 16'({4'd0, ctrx_r} + qx16) : 16'd0;
    sy   = sd.proj ? 16'({4'd0, ctry_r} - qz16) : 16'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= vd;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ox_r   <= sd.cam_x;
      oy_r   <= sd.cam_depth;
      oz_r   <= sd.cam_z;
      sx_r   <= sx;
      sy_r   <= sy;
      proj_r <= sd.proj;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, sy_r, sx_r, oz_r, oy_r, ox_r};
  assign out_tuser  = proj_r;

endmodule

`default_nettype wire
